// File: design/life_automaton_stencil_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the life automaton stencil
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_STENCIL_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_STENCIL_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define LAS_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger
`define LAS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: design/las_pkg.sv
// ----------------------------------------------------------------------------
// Life automaton stencil package
// Shared types and constants for the B3/S23 raster stencil.
// ----------------------------------------------------------------------------
package las_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_HEIGHT = 2'd1;

  // Grid size after reset, border included
  localparam int unsigned GridRst = 64;

  // One window column: bit 0 two rows up, bit 1 one row up, bit 2 current row
  localparam int unsigned CellW = 3;

  // Stream data width in bits
  localparam int unsigned TdataW = 8;

  // Position flags of the cell being accepted
  typedef struct packed {
    logic border;   // cell lies on the outer ring, forced dead
    logic produce;  // a result is due on this transaction
    logic last;     // result is the final interior cell of the frame
  } las_pos_t;

endpackage

// File: design/las_cell.sv
// ----------------------------------------------------------------------------
// Window column cell
// Holds one 3-cell column of the stencil window and hands it down the chain.
// ----------------------------------------------------------------------------
module las_cell
  import las_pkg::*;
(
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [CellW-1:0] col_i,
  output logic [CellW-1:0] col_o
);

  logic [CellW-1:0] col_q;

  // Take the neighbor's column on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// File: design/las_line_store.sv
// ----------------------------------------------------------------------------
// Line store
// Two previous rows per column: bit 0 two rows up, bit 1 one row up.
// ----------------------------------------------------------------------------
module las_line_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [1:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i
);

  logic [1:0] mem_q [Depth];
  logic [1:0] rd_data_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/las_pos.sv
// ----------------------------------------------------------------------------
// Raster position tracker
// Grid geometry registers, column/row counters and per-cell position flags.
// ----------------------------------------------------------------------------
module las_pos
  import las_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned ColW       = $clog2(MAX_WIDTH),
  parameter int unsigned RowW       = $clog2(MAX_HEIGHT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                accept_i,
  output logic [ColW-1:0]     col_o,
  output las_pos_t            info_o
);

  localparam int unsigned ExtW = (ColW + 1 > CfgDataW) ? ColW + 1 : CfgDataW;
  localparam int unsigned ExtH = (RowW + 1 > CfgDataW) ? RowW + 1 : CfgDataW;
  localparam logic [ColW-1:0] WLastRst =
    ColW'(((GridRst > MAX_WIDTH) ? MAX_WIDTH : GridRst) - 1);
  localparam logic [RowW-1:0] HLastRst =
    RowW'(((GridRst > MAX_HEIGHT) ? MAX_HEIGHT : GridRst) - 1);

  logic [ColW-1:0] w_last_q, w_last_d;
  logic [RowW-1:0] h_last_q, h_last_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] w_last_new;
  logic [RowW-1:0] h_last_new;
  logic [ExtW-1:0] wv;
  logic [ExtH-1:0] hv;
  logic            cfg_hit;
  logic            col_end, row_end;

  assign wv = ExtW'(cfg_wdata_i);
  assign hv = ExtH'(cfg_wdata_i);

  // Clamp written geometry to [3, MAX] and keep the last index
  always_comb begin
    if (wv < ExtW'(3)) begin
      w_last_new = ColW'(2);
    end else if (wv > ExtW'(MAX_WIDTH)) begin
      w_last_new = ColW'(MAX_WIDTH - 1);
    end else begin
      w_last_new = ColW'(wv - ExtW'(1));
    end
    if (hv < ExtH'(3)) begin
      h_last_new = RowW'(2);
    end else if (hv > ExtH'(MAX_HEIGHT)) begin
      h_last_new = RowW'(MAX_HEIGHT - 1);
    end else begin
      h_last_new = RowW'(hv - ExtH'(1));
    end
  end

  assign cfg_hit = cfg_we_i &&
                   ((cfg_index_i == REG_GRID_WIDTH) || (cfg_index_i == REG_GRID_HEIGHT));
  assign col_end = (col_q == w_last_q);
  assign row_end = (row_q == h_last_q);

  // Next geometry and raster position
  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_hit) begin
      // Any geometry write restarts the frame
      if (cfg_index_i == REG_GRID_WIDTH) begin
        w_last_d = w_last_new;
      end else begin
        h_last_d = h_last_new;
      end
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= WLastRst;
      h_last_q <= HLastRst;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Flags for the cell at the current position
  assign col_o          = col_q;
  assign info_o.border  = (row_q == '0) || row_end || (col_q == '0) || col_end;
  assign info_o.produce = (row_q >= RowW'(2)) && (col_q >= ColW'(2));
  assign info_o.last    = row_end && col_end;

endmodule

// File: design/life_automaton_stencil_top.sv
// The result for interior cell (r, c) comes with the transaction of cell (r+1, c+1): that
// cell waits in stage B, and the output register loads the result when the cell leaves it.
// Throughput: one cell per clock while no result is blocked on the output, set by the single line store read per cell.
// Reset: counters restart at the grid origin, geometry is 64 x 64, output empty.
// The line store is not cleared: stale bits are read only in the top two rows, which produce no result.
// ----------------------------------------------------------------------------
// Life automaton stencil top
// One B3/S23 generation over a raster cell stream with a bordered grid.
// ----------------------------------------------------------------------------
`include "life_automaton_stencil_top_assert.svh"

module life_automaton_stencil_top
  import las_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Input cell stream
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [TdataW-1:0]   s_tdata_i,   // [0] cell_alive
  // Result stream
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [TdataW-1:0]   m_tdata_o,   // [0] next_alive
  output logic                m_tlast_o    // last_cell
);

  localparam int unsigned ColW    = $clog2(MAX_WIDTH);
  localparam int unsigned WinHist = 2;   // stored columns of the 3-wide window

  logic             in_acc;
  logic [ColW-1:0]  col;
  las_pos_t         info;

  // Stage B: accepted cell waiting for its line store data
  logic             valid_b_q;
  logic [ColW-1:0]  col_b_q;
  logic             v_b_q;
  logic             prod_b_q;
  logic             last_b_q;
  logic             b_go;
  logic             out_free;
  logic [1:0]       rdata;
  logic [CellW-1:0] column;
  logic [CellW-1:0] chain_in [WinHist];
  logic [CellW-1:0] win [WinHist];
  logic [3:0]       n_live;
  logic             next_alive;

  // Output register
  logic             m_tvalid_q;
  logic             next_alive_q;
  logic             last_cell_q;

  assign in_acc     = s_tvalid_i && s_tready_o;
  assign out_free   = !m_tvalid_q || m_tready_i;
  assign b_go       = valid_b_q && (!prod_b_q || out_free);
  assign s_tready_o = !valid_b_q || b_go;

  // Position and geometry
  las_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (in_acc),
    .col_o       (col),
    .info_o      (info)
  );

  // Row history: read at accept, rewritten when the cell leaves stage B
  las_line_store #(
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col),
    .rd_data_o (rdata),
    .wr_en_i   (b_go),
    .wr_addr_i (col_b_q),
    .wr_data_i ({v_b_q, rdata[1]})
  );

  // Stage B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (in_acc) begin
      valid_b_q <= 1'b1;
    end else if (b_go) begin
      valid_b_q <= 1'b0;
    end
  end

  // Stage B payload; border cells enter as dead
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_b_q  <= col;
      v_b_q    <= s_tdata_i[0] && !info.border;
      prod_b_q <= info.produce;
      last_b_q <= info.last;
    end
  end

  assign column = {v_b_q, rdata[1], rdata[0]};

  // Window chain: newest column enters cell 0, older columns move along
  for (genvar k = 0; k < WinHist; k++) begin : g_win
    if (k == 0) begin : g_head
      assign chain_in[k] = column;
    end else begin : g_link
      assign chain_in[k] = win[k-1];
    end
    las_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (b_go),
      .col_i   (chain_in[k]),
      .col_o   (win[k])
    );
  end

  // Neighbor count over the window after this shift; centre is win[0][1]
  assign n_live = 4'(column[0]) + 4'(column[1]) + 4'(column[2])
                + 4'(win[0][0]) + 4'(win[0][2])
                + 4'(win[1][0]) + 4'(win[1][1]) + 4'(win[1][2]);
  assign next_alive = (n_live == 4'd3) || (win[0][1] && (n_live == 4'd2));

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (b_go && prod_b_q) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && prod_b_q) begin
      next_alive_q <= next_alive;
      last_cell_q  <= last_b_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {{(TdataW-1){1'b0}}, next_alive_q};
  assign m_tlast_o  = last_cell_q;

  // Assertions
  `LAS_ASSERT_SAME(ast_stall_blocks_input, valid_b_q && prod_b_q && m_tvalid_o && !m_tready_i, !s_tready_o, "input taken while a result is blocked")
  `LAS_ASSERT_SAME(ast_last_has_result, valid_b_q && last_b_q, prod_b_q, "last cell flagged without a result")
  `LAS_ASSERT_NEXT(ast_result_reaches_output, b_go && prod_b_q, m_tvalid_o, "result not loaded into output register")

endmodule

// File: bench/life_stencil_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life stencil checker
// Watches the config port and both streams of the stencil, keeps its own
// line stores and 3x3 window to work out the next generation of each
// interior cell, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module life_stencil_checker
  import las_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [TdataW-1:0]   s_tdata_i,   // [0] cell_alive
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [TdataW-1:0]   m_tdata_i,   // [0] next_alive
  input  logic                m_tlast_i,   // last_cell
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic alive;
    logic last;
  } gen_cell_t;

  // Line stores: cells two rows up and one row up, per column
  logic                row_above2 [MAX_WIDTH];
  logic                row_above1 [MAX_WIDTH];
  logic [8:0]          stencil_win;
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [CfgDataW-1:0] width_q;
  logic [CfgDataW-1:0] height_q;
  gen_cell_t           next_gen_q[$];
  int unsigned         errors;

  function automatic int unsigned clamp_dim(input logic [CfgDataW-1:0] v,
                                            input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Shift one arriving cell into the window, queue the result it releases
  function automatic void take_cell(input logic raw);
    int unsigned w, h, c, r, n;
    logic        v, up2, up1;
    gen_cell_t   res;
    w = clamp_dim(width_q, MAX_WIDTH);
    h = clamp_dim(height_q, MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    v = raw;
    // outer ring reads as dead
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) v = 1'b0;
    up2 = row_above2[c];
    up1 = row_above1[c];
    stencil_win   = {v, up1, up2, stencil_win[8:3]};
    row_above2[c] = up1;
    row_above1[c] = v;
    // window centre is interior cell (r-1, c-1)
    if (r >= 2 && c >= 2) begin
      n = $countones(stencil_win) - int'(stencil_win[4]);
      res.alive = stencil_win[4] ? (n == 2 || n == 3) : (n == 3);
      res.last  = (r == h - 1 && c == w - 1);
      next_gen_q.push_back(res);
    end
    if (c >= w - 1) begin
      c = 0;
      r = (r >= h - 1) ? 0 : r + 1;
    end else begin
      c++;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void check_result(input logic alive, input logic last);
    gen_cell_t want;
    if (next_gen_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t mismatch: result with none expected, got alive=%0b last=%0b",
                 $time, alive, last);
    end else begin
      want = next_gen_q.pop_front();
      if (want.alive !== alive || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("%0t mismatch: expected alive=%0b last=%0b, got alive=%0b last=%0b",
                   $time, want.alive, want.last, alive, last);
      end
    end
  endfunction

  // Observe transactions; result first so it meets the older expectations
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above2[i] = 1'b0;
        row_above1[i] = 1'b0;
      end
      stencil_win = '0;
      col_pos     = 0;
      row_pos     = 0;
      width_q     = CfgDataW'(GridRst);
      height_q    = CfgDataW'(GridRst);
      next_gen_q.delete();
      errors       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i[0], m_tlast_i);
      // a geometry write restarts the frame, other indexes are ignored
      if (cfg_we_i) begin
        if (cfg_index_i == REG_GRID_WIDTH) begin
          width_q = cfg_wdata_i;
          col_pos = 0;
          row_pos = 0;
        end else if (cfg_index_i == REG_GRID_HEIGHT) begin
          height_q = cfg_wdata_i;
          col_pos  = 0;
          row_pos  = 0;
        end
      end
      if (s_tvalid_i && s_tready_i) take_cell(s_tdata_i[0]);
      fail_count_o <= errors;
      pending_o    <= next_gen_q.size();
    end
  end

endmodule

// File: bench/life_automaton_stencil_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life automaton stencil testbench
// Streams bordered cell grids of many sizes through the stencil, with
// random gaps on the input and random stalls on the output, and lets the
// checker compare every next-generation cell.
// ----------------------------------------------------------------------------
module life_automaton_stencil_top_tb;
  import las_pkg::*;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  // Indexes with no register behind them
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 300_000;
  localparam int unsigned PHASE_CELLS   = 240;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [TdataW-1:0]   s_tdata_i;   // [0] cell_alive
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [TdataW-1:0]   m_tdata_o;   // [0] next_alive
  logic                m_tlast_o;   // last_cell

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  int unsigned cells_sent;
  int unsigned grid_w;
  int unsigned grid_h;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  life_automaton_stencil_top #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  life_stencil_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_i  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_i   (m_tdata_o),
    .m_tlast_i   (m_tlast_o),
    .fail_count_o(mismatch_cnt),
    .pending_o   (pending_cnt)
  );

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned fold_dim(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly small grids, now and then a value below the minimum
  function automatic int unsigned rand_dim();
    return ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
  endfunction

  // One cell transaction; valid stays up for a back-to-back follower
  task automatic push_cell(input logic [TdataW-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    cells_sent++;
  endtask

  // Random cells, padding bits random too
  task automatic send_cells(input int unsigned count, input int unsigned density);
    logic [TdataW-1:0] data;
    for (int unsigned i = 0; i < count; i++) begin
      data    = TdataW'($urandom_range(255));
      data[0] = ($urandom_range(99) < density);
      push_cell(data);
    end
  endtask

  // Stop sending and let every outstanding result drain
  task automatic quiesce();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Single register write; hold_we keeps the enable up for a follow-on write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int unsigned val,
                           input bit hold_we);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    @(posedge clk_i);
    if (!hold_we) cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(input int unsigned w, input int unsigned h);
    cfg_write(REG_GRID_WIDTH, w, 1'b1);
    cfg_write(REG_GRID_HEIGHT, h, 1'b0);
    grid_w = fold_dim(w, MAX_WIDTH);
    grid_h = fold_dim(h, MAX_HEIGHT);
  endtask

  // Optional reconfiguration, then whole frames or a partial run
  task automatic random_segment();
    int unsigned pick, density, count, dim;
    pick = $urandom_range(99);
    if (pick < 90) quiesce();
    if (pick < 55) begin
      set_grid(rand_dim(), rand_dim());
    end else if (pick < 68) begin
      dim = rand_dim();
      cfg_write(REG_GRID_WIDTH, dim, 1'b0);
      grid_w = fold_dim(dim, MAX_WIDTH);
    end else if (pick < 80) begin
      dim = rand_dim();
      cfg_write(REG_GRID_HEIGHT, dim, 1'b0);
      grid_h = fold_dim(dim, MAX_HEIGHT);
    end else if (pick < 90) begin
      cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom_range(2047), 1'b0);
    end
    density = $urandom_range(15, 70);
    if ($urandom_range(2) == 0)
      count = $urandom_range(1, 2 * grid_w * grid_h);
    else
      count = grid_w * grid_h * $urandom_range(1, 2);
    send_cells(count, density);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned target;
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    target = cells_sent + PHASE_CELLS;
    while (cells_sent < target) random_segment();
  endtask

  initial begin
    logic [TdataW-1:0] data;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= REG_GRID_WIDTH;
    cfg_wdata_i     <= '0;
    s_tvalid_i      <= 1'b0;
    s_tdata_i       <= '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    cells_sent      = 0;
    grid_w          = GridRst;
    grid_h          = GridRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest grid, sizes under the minimum, every input bit high:
    // border reads dead, so the lone interior cell dies
    set_grid(0, 2);
    for (int i = 0; i < 9; i++) push_cell('1);

    // 4x4 with a 2x2 block inside, live border ignored; a write to an
    // unused index in mid-frame must not restart the frame
    quiesce();
    set_grid(4, 4);
    for (int unsigned i = 0; i < 16; i++) begin
      if (i == 6) begin
        quiesce();
        cfg_write(REG_SPARE_LO, 2047, 1'b0);
      end
      data    = TdataW'($urandom_range(255));
      data[0] = (i / 4 inside {1, 2} && i % 4 inside {1, 2}) ? 1'b1 : data[0];
      push_cell(data);
    end

    // Register values past the maximum: a short run along the widest row,
    // then the top of the tallest grid
    quiesce();
    set_grid(2047, 0);
    send_cells(100, 40);
    quiesce();
    set_grid(2, 2047);
    send_cells(150, 40);

    // Back to a small grid for the random phases
    quiesce();
    set_grid(8, 6);

    run_phase(0, 0);
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(28, 28);

    quiesce();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
